### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition observed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

### rtl/core/dps_pkg.sv
`default_nettype none

package dps_pkg;

  localparam int unsigned NumCh     = 4;
  localparam int unsigned ThrW      = 22;
  localparam int unsigned CntW      = 16;
  localparam int unsigned OverW     = 6;
  localparam int unsigned ShuntW    = 16;
  localparam int unsigned CurW      = 23;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [OverW-1:0] OverLimit = 6'd50;

  localparam logic [CmdW-1:0] CMD_TICK      = 3'd0;
  localparam logic [CmdW-1:0] CMD_HEARTBEAT = 3'd1;
  localparam logic [CmdW-1:0] CMD_SAMPLE    = 3'd2;
  localparam logic [CmdW-1:0] CMD_CYCLE     = 3'd3;
  localparam logic [CmdW-1:0] CMD_TOGGLE    = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_THR_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_THR_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THR_C   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THR_D   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WD_EN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OC_EN   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OFF_T   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HB_TO   = 3'd7;

  localparam logic [ThrW-1:0] ThrReset  = 22'd200000;
  localparam logic [CntW-1:0] TimeReset = 16'd2000;

  typedef struct packed {
    logic            wd_en;
    logic            oc_en;
    logic [CntW-1:0] off_time;
    logic [CntW-1:0] hb_timeout;
  } cfg_t;

  typedef struct packed {
    logic power_off;
    logic pending;
    logic wd_trip;
    logic oc_trip;
    logic restored;
  } lane_res_t;

endpackage

`default_nettype wire

### rtl/core/dps_scale.sv
`default_nettype none

// Converts a raw shunt reading to microamps: s * 1000 / 12, truncated toward zero.
// Works on the magnitude: |s| * 250 / 3 = 83 * |s| + floor(|s| / 3).
module dps_scale (
  input  wire logic signed [dps_pkg::ShuntW-1:0] shunt_i,
  output logic signed [dps_pkg::CurW-1:0]        current_o
);

  localparam logic [15:0] Recip3 = 16'd43691;  // ceil(2^17 / 3)

  logic signed [16:0] sx;
  logic signed [16:0] sneg;
  logic [15:0]        mag;
  logic [31:0]        prod;
  logic [21:0]        mag83;
  logic [21:0]        res;

  always_comb begin
    sx    = 17'(shunt_i);
    sneg  = -sx;
    mag   = shunt_i[15] ? sneg[15:0] : sx[15:0];
    prod  = mag * Recip3;
    mag83 = 22'(mag) * 22'd83;
    res   = mag83 + 22'(prod[31:17]);
    current_o = shunt_i[15] ? -$signed({1'b0, res}) : $signed({1'b0, res});
  end

endmodule

`default_nettype wire

### rtl/core/dps_lane.sv
`default_nettype none

// State and decisions of one supervised channel.
module dps_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic [dps_pkg::CmdW-1:0]          cmd_i,
  input  wire logic                              sel_i,
  input  wire logic signed [dps_pkg::CurW-1:0]   current_i,
  input  wire logic [dps_pkg::ThrW-1:0]          threshold_i,
  input  wire dps_pkg::cfg_t                     cfg_i,
  output dps_pkg::lane_res_t                     res_o
);

  logic                         power_off_q, power_off_d;
  logic                         pending_q, pending_d;
  logic [dps_pkg::CntW-1:0]     off_el_q, off_el_d;
  logic [dps_pkg::CntW-1:0]     sil_el_q, sil_el_d;
  logic [dps_pkg::OverW-1:0]    over_q, over_d;

  logic [dps_pkg::CntW-1:0]     off_inc, sil_inc;
  logic [dps_pkg::OverW-1:0]    over_inc;
  logic                         restore, wd_trip, oc_trip, above;

  always_comb begin
    off_inc  = (&off_el_q) ? off_el_q : off_el_q + 1'b1;
    sil_inc  = (&sil_el_q) ? sil_el_q : sil_el_q + 1'b1;
    over_inc = (&over_q)   ? over_q   : over_q + 1'b1;
    above    = current_i > $signed({1'b0, threshold_i});

    power_off_d = power_off_q;
    pending_d   = pending_q;
    off_el_d    = off_el_q;
    sil_el_d    = sil_el_q;
    over_d      = over_q;
    restore     = 1'b0;
    wd_trip     = 1'b0;
    oc_trip     = 1'b0;

    case (cmd_i)
      dps_pkg::CMD_TICK: begin
        off_el_d = off_inc;
        sil_el_d = sil_inc;
        restore  = pending_q && (off_inc > cfg_i.off_time);
        if (restore) begin
          power_off_d = 1'b0;
          pending_d   = 1'b0;
          sil_el_d    = '0;
        end
        wd_trip = cfg_i.wd_en && !pending_d && (sil_el_d > cfg_i.hb_timeout);
        if (wd_trip) begin
          power_off_d = 1'b1;
          pending_d   = 1'b1;
          off_el_d    = '0;
        end
      end
      dps_pkg::CMD_HEARTBEAT: begin
        if (sel_i) begin
          sil_el_d = '0;
        end
      end
      dps_pkg::CMD_SAMPLE: begin
        over_d  = above ? over_inc : '0;
        oc_trip = cfg_i.oc_en && (over_d > dps_pkg::OverLimit);
        if (oc_trip) begin
          over_d      = '0;
          power_off_d = 1'b1;
          pending_d   = 1'b1;
          off_el_d    = '0;
        end
      end
      dps_pkg::CMD_CYCLE: begin
        if (sel_i) begin
          power_off_d = 1'b1;
          pending_d   = 1'b1;
          off_el_d    = '0;
        end
      end
      dps_pkg::CMD_TOGGLE: begin
        power_off_d = power_off_q ^ sel_i;
      end
      default: begin
      end
    endcase

    res_o.power_off = power_off_d;
    res_o.pending   = pending_d;
    res_o.wd_trip   = wd_trip;
    res_o.oc_trip   = oc_trip;
    res_o.restored  = restore;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_off_q <= 1'b0;
      pending_q   <= 1'b0;
      off_el_q    <= '0;
      sil_el_q    <= '0;
      over_q      <= '0;
    end else if (step_i) begin
      power_off_q <= power_off_d;
      pending_q   <= pending_d;
      off_el_q    <= off_el_d;
      sil_el_q    <= sil_el_d;
      over_q      <= over_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dut_power_supervisor.sv
// Channel     | Direction | Contents
// s_axis      | in        | tuser: cmd; tdata: channel_mask, shunt_a..shunt_d
// m_axis      | out       | tdata: five channel masks, current_a..current_d
// cfg         | in        | write enable, register index, write data
//
// One request per clock is taken unless the output stalls with stage one full.
// Stage one scales the four shunt readings, stage two updates the four channel
// lanes and loads the output register; the lane state update sets the pace.
// Reset brings all channels powered, counters cleared and registers to defaults.
// A stalled output holds its result; the input side keeps moving while the
// output register is empty or being drained.
`default_nettype none

`include "assert_macros.svh"

module dut_power_supervisor (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] channel_mask, [19:4] shunt_a, [35:20] shunt_b, [51:36] shunt_c,
  // [67:52] shunt_d, [71:68] zero
  input  wire logic [71:0]                       s_axis_tdata,
  // [2:0] cmd
  input  wire logic [dps_pkg::CmdW-1:0]          s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] power_off_mask, [7:4] pending_mask, [11:8] watchdog_trip_mask,
  // [15:12] overcurrent_trip_mask, [19:16] restored_mask, [42:20] current_a,
  // [65:43] current_b, [88:66] current_c, [111:89] current_d
  output logic [111:0]                           m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [dps_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [dps_pkg::ThrW-1:0]          cfg_wdata_i
);

  localparam int unsigned N = dps_pkg::NumCh;

  // Configuration registers.
  logic [dps_pkg::ThrW-1:0] thr_q [N];
  dps_pkg::cfg_t            cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        thr_q[i] <= dps_pkg::ThrReset;
      end
      cfg_q.wd_en      <= 1'b1;
      cfg_q.oc_en      <= 1'b1;
      cfg_q.off_time   <= dps_pkg::TimeReset;
      cfg_q.hb_timeout <= dps_pkg::TimeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dps_pkg::REG_THR_A: thr_q[0] <= cfg_wdata_i;
        dps_pkg::REG_THR_B: thr_q[1] <= cfg_wdata_i;
        dps_pkg::REG_THR_C: thr_q[2] <= cfg_wdata_i;
        dps_pkg::REG_THR_D: thr_q[3] <= cfg_wdata_i;
        dps_pkg::REG_WD_EN: cfg_q.wd_en <= cfg_wdata_i[0];
        dps_pkg::REG_OC_EN: cfg_q.oc_en <= cfg_wdata_i[0];
        dps_pkg::REG_OFF_T: cfg_q.off_time <= cfg_wdata_i[dps_pkg::CntW-1:0];
        dps_pkg::REG_HB_TO: cfg_q.hb_timeout <= cfg_wdata_i[dps_pkg::CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_v_q, out_v_q;
  logic adv_out, s1_fire, in_fire;

  assign adv_out       = !out_v_q || m_axis_tready;
  assign s1_fire       = s1_v_q && adv_out;
  assign s_axis_tready = !s1_v_q || adv_out;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // Stage one: scaling.
  logic signed [dps_pkg::CurW-1:0] cur_c  [N];
  logic signed [dps_pkg::CurW-1:0] cur_q  [N];
  logic [dps_pkg::CmdW-1:0]        cmd_q;
  logic [N-1:0]                    mask_q;

  for (genvar g = 0; g < N; g++) begin : g_scale
    dps_scale u_scale (
      .shunt_i   (s_axis_tdata[4 + g*dps_pkg::ShuntW +: dps_pkg::ShuntW]),
      .current_o (cur_c[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tuser;
      mask_q <= s_axis_tdata[N-1:0];
      for (int i = 0; i < N; i++) begin
        cur_q[i] <= cur_c[i];
      end
    end
  end

  // Stage two: channel lanes, then the merge into the output register.
  dps_pkg::lane_res_t lane_res [N];

  for (genvar g = 0; g < N; g++) begin : g_lane
    dps_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (s1_fire),
      .cmd_i       (cmd_q),
      .sel_i       (mask_q[g]),
      .current_i   (cur_q[g]),
      .threshold_i (thr_q[g]),
      .cfg_i       (cfg_q),
      .res_o       (lane_res[g])
    );
  end

  logic [N-1:0] po_m, pend_m, wd_m, oc_m, rest_m;
  logic         is_sample;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      po_m[i]   = lane_res[i].power_off;
      pend_m[i] = lane_res[i].pending;
      wd_m[i]   = lane_res[i].wd_trip;
      oc_m[i]   = lane_res[i].oc_trip;
      rest_m[i] = lane_res[i].restored;
    end
    is_sample = (cmd_q == dps_pkg::CMD_SAMPLE);
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      m_axis_tdata[3:0]   <= po_m;
      m_axis_tdata[7:4]   <= pend_m;
      m_axis_tdata[11:8]  <= wd_m;
      m_axis_tdata[15:12] <= oc_m;
      m_axis_tdata[19:16] <= rest_m;
      for (int i = 0; i < N; i++) begin
        m_axis_tdata[20 + i*dps_pkg::CurW +: dps_pkg::CurW] <=
          is_sample ? cur_q[i] : '0;
      end
    end
  end

  // A restored channel is powered and no longer waiting.
  `ASSERT_NEVER(a_restore_clean, s1_fire && ((rest_m & (po_m | pend_m)) != '0))
  // Any trip leaves the channel waiting for its timed restore.
  `ASSERT_NEVER(a_trip_pending, s1_fire && (((wd_m | oc_m) & ~pend_m) != '0))
  // The watchdog and overcurrent paths never fire on the same request.
  `ASSERT_IMPLIES(a_trip_exclusive, s1_fire && (oc_m != '0), wd_m == '0)

endmodule

`default_nettype wire
